>>> hw/rtl/prfo_pkg.sv
// Shared types, sizes and codes of the packet ring FIFO with overwrite.
`timescale 1ns / 1ps

package prfo_pkg;

	// Ring geometry
	localparam int SLOTS       = 16;
	localparam int SLOT_LOG2   = $clog2(SLOTS);
	localparam int MAX_PAYLOAD = 64;
	localparam int PAY_LOG2    = $clog2(MAX_PAYLOAD);
	localparam int MEM_DEPTH   = SLOTS * MAX_PAYLOAD;
	localparam int ADDR_W      = SLOT_LOG2 + PAY_LOG2;
	localparam int CNT_W       = SLOT_LOG2 + 1;
	localparam int LEN_W       = 7;
	localparam int LOG2_W      = 3;
	localparam int K_W         = $clog2(SLOT_LOG2 + 1) + 1;
	localparam int OCC_W       = 4;

	// Queue sizes
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = CQ_PTR_W + 1;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = OQ_PTR_W + 1;

	// Configuration registers
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RING_LOG2   = 1'd1;
	localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD = 7'd64;
	localparam logic [LOG2_W-1:0] RST_RING_LOG2   = 3'd4;

	typedef enum logic [2:0] {
		ST_BYTE_TAKEN  = 3'd0,
		ST_COMMITTED   = 3'd1,
		ST_COMMIT_DROP = 3'd2,
		ST_FULL_REJECT = 3'd3,
		ST_OVERSIZE    = 3'd4,
		ST_POP_DATA    = 3'd5,
		ST_POP_EMPTY   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CMD_PUSH_BYTE = 2'd0,
		CMD_PUSH_END  = 2'd1,
		CMD_POP       = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data_byte;
		logic       has_byte;
		logic       overwrite_oldest;
	} cmd_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       read_byte;
		logic             read_has_byte;
		logic             read_last;
		logic [OCC_W-1:0] occupancy;
	} result_t;

	typedef struct packed {
		logic [LEN_W-1:0]  max_payload;
		logic [LOG2_W-1:0] ring_log2;
	} cfg_t;

endpackage

>>> hw/rtl/prfo_front.sv
// Front end: accepts items, classifies them and queues commands for the back end.
`timescale 1ns / 1ps

module prfo_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              action,
	input  logic [7:0]        data_byte,
	input  logic              has_byte,
	input  logic              last_byte,
	input  logic              overwrite_oldest,
	output logic              cmd_valid,
	output prfo_pkg::cmd_t    cmd,
	input  logic              cmd_ready
);

	prfo_pkg::cmd_t                 cq_q [prfo_pkg::CQ_DEPTH];
	logic [prfo_pkg::CQ_PTR_W-1:0]  wr_ptr_q;
	logic [prfo_pkg::CQ_PTR_W-1:0]  rd_ptr_q;
	logic [prfo_pkg::CQ_CNT_W-1:0]  cnt_q;
	prfo_pkg::cmd_t                 cmd_new;
	logic                           in_take;
	logic                           out_take;

	// Classify the incoming item
	always_comb begin
		cmd_new.data_byte        = data_byte;
		cmd_new.has_byte         = has_byte;
		cmd_new.overwrite_oldest = overwrite_oldest;
		if (action) begin
			cmd_new.kind = prfo_pkg::CMD_POP;
		end else if (last_byte) begin
			cmd_new.kind = prfo_pkg::CMD_PUSH_END;
		end else begin
			cmd_new.kind = prfo_pkg::CMD_PUSH_BYTE;
		end
	end

	assign full      = (cnt_q == prfo_pkg::CQ_CNT_W'(prfo_pkg::CQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cq_q[rd_ptr_q];
	assign in_take   = push && !full;
	assign out_take  = cmd_valid && cmd_ready;

	// Store queued commands
	always_ff @(posedge clk) begin
		if (in_take) begin
			cq_q[wr_ptr_q] <= cmd_new;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_take) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + prfo_pkg::CQ_CNT_W'(in_take) - prfo_pkg::CQ_CNT_W'(out_take);
		end
	end

endmodule

>>> hw/rtl/prfo_back.sv
// Back end: ring state, payload memory, commit checks and pop streaming.
`timescale 1ns / 1ps

module prfo_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  prfo_pkg::cfg_t                 cfg,
	input  logic                           cmd_valid,
	input  prfo_pkg::cmd_t                 cmd,
	output logic                           cmd_ready,
	input  logic [prfo_pkg::OQ_CNT_W-1:0]  oq_count,
	output logic                           res_we,
	output prfo_pkg::result_t              res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_STREAM,
		S_DRAIN
	} state_t;

	state_t                            state_q;
	logic [prfo_pkg::CNT_W-1:0]        wr_cnt_q;
	logic [prfo_pkg::CNT_W-1:0]        rd_cnt_q;
	logic [prfo_pkg::LEN_W-1:0]        fill_q;
	logic                              ovf_q;
	logic [prfo_pkg::SLOT_LOG2-1:0]    tail_q;
	logic [prfo_pkg::LEN_W-1:0]        len_q;
	logic [prfo_pkg::PAY_LOG2-1:0]     idx_q;
	logic                              rd_vld_s1;
	logic                              rd_last_s1;
	logic [7:0]                        rdata_s1;

	logic [7:0]                        mem [prfo_pkg::MEM_DEPTH];
	logic [prfo_pkg::LEN_W-1:0]        slot_len_q [prfo_pkg::SLOTS];

	logic [prfo_pkg::K_W-1:0]          k;
	logic [prfo_pkg::CNT_W-1:0]        slots_w;
	logic [prfo_pkg::CNT_W-1:0]        usable;
	logic [prfo_pkg::SLOT_LOG2-1:0]    slot_mask;
	logic [prfo_pkg::SLOT_LOG2-1:0]    head;
	logic [prfo_pkg::SLOT_LOG2-1:0]    tail_now;
	logic [prfo_pkg::CNT_W-1:0]        occ;
	logic [prfo_pkg::LEN_W-1:0]        limit;
	logic                              take;
	logic                              store_ok;
	logic [prfo_pkg::LEN_W-1:0]        fill_new;
	logic                              ovf_new;
	prfo_pkg::status_t                 push_status;
	logic                              commit;
	logic                              drop;
	logic [prfo_pkg::CNT_W-1:0]        wr_next;
	logic [prfo_pkg::CNT_W-1:0]        rd_next;
	logic [prfo_pkg::LEN_W-1:0]        len_raw;
	logic [prfo_pkg::LEN_W-1:0]        pop_len;
	logic                              issue;
	logic                              is_last;
	logic                              mem_we;
	logic [prfo_pkg::ADDR_W-1:0]       waddr;
	logic [prfo_pkg::ADDR_W-1:0]       raddr;

	// Ring geometry and limits from configuration
	always_comb begin
		if (cfg.ring_log2 == '0) begin
			k = prfo_pkg::K_W'(1);
		end else if (prfo_pkg::K_W'(cfg.ring_log2) > prfo_pkg::K_W'(prfo_pkg::SLOT_LOG2)) begin
			k = prfo_pkg::K_W'(prfo_pkg::SLOT_LOG2);
		end else begin
			k = prfo_pkg::K_W'(cfg.ring_log2);
		end
		slots_w   = prfo_pkg::CNT_W'(1) << k;
		usable    = slots_w - prfo_pkg::CNT_W'(1);
		slot_mask = usable[prfo_pkg::SLOT_LOG2-1:0];
		head      = wr_cnt_q[prfo_pkg::SLOT_LOG2-1:0] & slot_mask;
		tail_now  = rd_cnt_q[prfo_pkg::SLOT_LOG2-1:0] & slot_mask;
		occ       = wr_cnt_q - rd_cnt_q;
		if (cfg.max_payload > prfo_pkg::LEN_W'(prfo_pkg::MAX_PAYLOAD)) begin
			limit = prfo_pkg::LEN_W'(prfo_pkg::MAX_PAYLOAD);
		end else begin
			limit = cfg.max_payload;
		end
	end

	assign cmd_ready = (state_q == S_IDLE) && (oq_count < prfo_pkg::OQ_CNT_W'(prfo_pkg::OQ_DEPTH));
	assign take      = cmd_valid && cmd_ready;

	// Push byte store and final commit check
	always_comb begin
		store_ok = cmd.has_byte && (fill_q < limit);
		fill_new = fill_q + prfo_pkg::LEN_W'(store_ok);
		ovf_new  = ovf_q || (cmd.has_byte && !store_ok);
		if (ovf_new) begin
			push_status = prfo_pkg::ST_OVERSIZE;
		end else if (occ >= usable) begin
			push_status = cmd.overwrite_oldest ? prfo_pkg::ST_COMMIT_DROP
			                                   : prfo_pkg::ST_FULL_REJECT;
		end else begin
			push_status = prfo_pkg::ST_COMMITTED;
		end
		commit  = (push_status == prfo_pkg::ST_COMMITTED) ||
		          (push_status == prfo_pkg::ST_COMMIT_DROP);
		drop    = (push_status == prfo_pkg::ST_COMMIT_DROP);
		wr_next = wr_cnt_q + prfo_pkg::CNT_W'(commit);
		rd_next = rd_cnt_q + prfo_pkg::CNT_W'(drop);
		mem_we  = take && (cmd.kind != prfo_pkg::CMD_POP) && store_ok;
		waddr   = {head, fill_q[prfo_pkg::PAY_LOG2-1:0]};
	end

	// Pop length lookup and stream read control
	always_comb begin
		len_raw = slot_len_q[tail_now];
		if (len_raw > prfo_pkg::LEN_W'(prfo_pkg::MAX_PAYLOAD)) begin
			pop_len = prfo_pkg::LEN_W'(prfo_pkg::MAX_PAYLOAD);
		end else begin
			pop_len = len_raw;
		end
		issue   = (state_q == S_STREAM) &&
		          ((oq_count + prfo_pkg::OQ_CNT_W'(rd_vld_s1)) <
		           prfo_pkg::OQ_CNT_W'(prfo_pkg::OQ_DEPTH));
		is_last = (prfo_pkg::LEN_W'(idx_q) == (len_q - prfo_pkg::LEN_W'(1)));
		raddr   = {tail_q, idx_q};
	end

	// Build the result for the output queue
	always_comb begin
		res_we            = 1'b0;
		res.status        = prfo_pkg::ST_BYTE_TAKEN;
		res.read_byte     = '0;
		res.read_has_byte = 1'b0;
		res.read_last     = 1'b1;
		res.occupancy     = prfo_pkg::OCC_W'(occ);
		if (rd_vld_s1) begin
			res_we            = 1'b1;
			res.status        = prfo_pkg::ST_POP_DATA;
			res.read_byte     = rdata_s1;
			res.read_has_byte = 1'b1;
			res.read_last     = rd_last_s1;
		end else if (take) begin
			case (cmd.kind)
				prfo_pkg::CMD_PUSH_BYTE: begin
					res_we = 1'b1;
				end
				prfo_pkg::CMD_PUSH_END: begin
					res_we        = 1'b1;
					res.status    = push_status;
					res.occupancy = prfo_pkg::OCC_W'(wr_next - rd_next);
				end
				prfo_pkg::CMD_POP: begin
					if (occ == '0) begin
						res_we     = 1'b1;
						res.status = prfo_pkg::ST_POP_EMPTY;
					end else if (pop_len == '0) begin
						res_we        = 1'b1;
						res.status    = prfo_pkg::ST_POP_DATA;
						res.occupancy = prfo_pkg::OCC_W'(occ - prfo_pkg::CNT_W'(1));
					end
				end
				default: begin
					res_we = 1'b0;
				end
			endcase
		end
	end

	// Payload memory and slot lengths
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= cmd.data_byte;
		end
		if (issue) begin
			rdata_s1 <= mem[raddr];
		end
		if (take && (cmd.kind == prfo_pkg::CMD_PUSH_END) && commit) begin
			slot_len_q[head] <= fill_new;
		end
	end

	// Sequencer: ring counters, fill tracking and pop streaming
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wr_cnt_q   <= '0;
			rd_cnt_q   <= '0;
			fill_q     <= '0;
			ovf_q      <= 1'b0;
			tail_q     <= '0;
			len_q      <= '0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (cmd.kind)
							prfo_pkg::CMD_PUSH_BYTE: begin
								fill_q <= fill_new;
								ovf_q  <= ovf_new;
							end
							prfo_pkg::CMD_PUSH_END: begin
								fill_q   <= '0;
								ovf_q    <= 1'b0;
								wr_cnt_q <= wr_next;
								rd_cnt_q <= rd_next;
							end
							prfo_pkg::CMD_POP: begin
								if (occ != '0) begin
									rd_cnt_q <= rd_cnt_q + prfo_pkg::CNT_W'(1);
									if (pop_len != '0) begin
										tail_q  <= tail_now;
										len_q   <= pop_len;
										idx_q   <= '0;
										state_q <= S_STREAM;
									end
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_STREAM: begin
					if (issue) begin
						rd_vld_s1  <= 1'b1;
						rd_last_s1 <= is_last;
						idx_q      <= idx_q + 1'b1;
						if (is_last) begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/prfo_out_queue.sv
// Result queue between the back end and the result ports.
`timescale 1ns / 1ps

module prfo_out_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  prfo_pkg::result_t              wr_data,
	input  logic                           rd_en,
	output prfo_pkg::result_t              head,
	output logic                           empty,
	output logic [prfo_pkg::OQ_CNT_W-1:0]  count
);

	prfo_pkg::result_t              oq_q [prfo_pkg::OQ_DEPTH];
	logic [prfo_pkg::OQ_PTR_W-1:0]  wr_ptr_q;
	logic [prfo_pkg::OQ_PTR_W-1:0]  rd_ptr_q;
	logic [prfo_pkg::OQ_CNT_W-1:0]  cnt_q;
	logic                           out_take;

	assign head     = oq_q[rd_ptr_q];
	assign empty    = (cnt_q == '0);
	assign count    = cnt_q;
	assign out_take = rd_en && !empty;

	// Hold results until taken
	always_ff @(posedge clk) begin
		if (wr_en) begin
			oq_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + prfo_pkg::OQ_CNT_W'(wr_en) - prfo_pkg::OQ_CNT_W'(out_take);
		end
	end

endmodule

>>> hw/rtl/packet_ring_fifo_overwrite.sv
// Top level of the packet ring FIFO with overwrite: config registers and wiring.
`timescale 1ns / 1ps

// Usage:
// - Input side is a queue: drive action and payload, raise push; the item is
//   taken when push is high and full is low. A message is a run of push items
//   closed by one with last_byte set; a pop item streams out the oldest message.
// - Result side is a queue: while empty is low the oldest result is on the
//   result ports; pop takes it. Every push item gives one result; a pop gives
//   one result per payload byte (or one result for an empty message or ring).
// - Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high. Write only while the block is idle.
// - Path: a push result goes through the command and result queues. A pop
//   goes through the command queue, stream state, read register and result
//   queue, then gives one byte per cycle while the result side keeps up.
// - Throughput: push items run at one per cycle unless a pop streams or the
//   result side stalls. A pop holds the back end: take, a read per byte, drain.
// - A four-entry result queue decouples the sides; when the receiver stalls,
//   the back end holds and, once the two-entry command queue fills, full rises.
// - Reset clears counters and queues (ring empty, no partial message) and sets
//   max_payload_bytes to 64 and ring_size_log2 to 4.
module packet_ring_fifo_overwrite (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            action,
	input  logic [7:0]                      data_byte,
	input  logic                            has_byte,
	input  logic                            last_byte,
	input  logic                            overwrite_oldest,
	output logic                            empty,
	input  logic                            pop,
	output logic [2:0]                      status,
	output logic [7:0]                      read_byte,
	output logic                            read_has_byte,
	output logic                            read_last,
	output logic [prfo_pkg::OCC_W-1:0]      occupancy,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [prfo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prfo_pkg::LEN_W-1:0]      cfg_data
);

	prfo_pkg::cfg_t                 cfg_q;
	logic                           cmd_valid;
	prfo_pkg::cmd_t                 cmd;
	logic                           cmd_ready;
	logic [prfo_pkg::OQ_CNT_W-1:0]  oq_count;
	logic                           res_we;
	prfo_pkg::result_t              res;
	prfo_pkg::result_t              head;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload <= prfo_pkg::RST_MAX_PAYLOAD;
			cfg_q.ring_log2   <= prfo_pkg::RST_RING_LOG2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				prfo_pkg::REG_MAX_PAYLOAD: begin
					cfg_q.max_payload <= cfg_data;
				end
				prfo_pkg::REG_RING_LOG2: begin
					cfg_q.ring_log2 <= cfg_data[prfo_pkg::LOG2_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	prfo_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.action           (action),
		.data_byte        (data_byte),
		.has_byte         (has_byte),
		.last_byte        (last_byte),
		.overwrite_oldest (overwrite_oldest),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.cmd_ready        (cmd_ready)
	);

	prfo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.oq_count  (oq_count),
		.res_we    (res_we),
		.res       (res)
	);

	prfo_out_queue u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_we),
		.wr_data (res),
		.rd_en   (pop),
		.head    (head),
		.empty   (empty),
		.count   (oq_count)
	);

	// Drive result ports from the queue head
	assign status        = head.status;
	assign read_byte     = head.read_byte;
	assign read_has_byte = head.read_has_byte;
	assign read_last     = head.read_last;
	assign occupancy     = head.occupancy;

`ifndef NO_ASSERTIONS
	// The back end never writes a result into a full output queue
	a_no_oq_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_we |-> (oq_count < prfo_pkg::OQ_CNT_W'(prfo_pkg::OQ_DEPTH)))
		else $error("result written into full output queue");

	// Only popped data carries a payload byte
	a_byte_only_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && read_has_byte) |-> (status == prfo_pkg::ST_POP_DATA))
		else $error("payload byte on a non-pop result");

	// Every result other than popped data closes its item
	a_last_on_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status != prfo_pkg::ST_POP_DATA)) |-> read_last)
		else $error("single result without last mark");
`endif

endmodule

>>> verif/packet_ring_fifo_overwrite_tb.sv
// Self-checking testbench for the packet ring FIFO with overwrite.
`timescale 1ns / 1ps

module packet_ring_fifo_overwrite_tb;
	import prfo_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic                 action;
	logic [7:0]           data_byte;
	logic                 has_byte;
	logic                 last_byte;
	logic                 overwrite_oldest;
	logic                 empty;
	logic                 pop;
	logic [2:0]           status;
	logic [7:0]           read_byte;
	logic                 read_has_byte;
	logic                 read_last;
	logic [OCC_W-1:0]     occupancy;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0]     cfg_data;

	// Ring mirror: payload bytes, lengths, message counters, open message
	logic [7:0]       ring_bytes [MEM_DEPTH];
	logic [LEN_W-1:0] ring_lengths [SLOTS];
	logic [CNT_W-1:0] msgs_written;
	logic [CNT_W-1:0] msgs_read;
	logic [LEN_W-1:0] open_fill;
	logic             open_too_long;
	logic [LEN_W-1:0] cfg_max_payload;
	logic [LOG2_W-1:0] cfg_ring_log2;

	result_t expected_results [$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int items_accepted;
	int results_checked;
	int cfg_writes;
	int full_stall_cycles;
	int error_count;

	packet_ring_fifo_overwrite u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.action           (action),
		.data_byte        (data_byte),
		.has_byte         (has_byte),
		.last_byte        (last_byte),
		.overwrite_oldest (overwrite_oldest),
		.empty            (empty),
		.pop              (pop),
		.status           (status),
		.read_byte        (read_byte),
		.read_has_byte    (read_has_byte),
		.read_last        (read_last),
		.occupancy        (occupancy),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("packet_ring_fifo_overwrite_tb: done, errors");
		$finish;
	end

	// Slots in use after clamping the size register
	function automatic int slots_active();
		int k;
		k = cfg_ring_log2;
		if (k < 1) k = 1;
		while (k > 1 && (1 << k) > SLOTS) k--;
		return 1 << k;
	endfunction

	function automatic logic [CNT_W-1:0] stored_msgs();
		return msgs_written - msgs_read;
	endfunction

	task automatic add_expect(status_t st, logic [7:0] b, logic hb, logic lst);
		result_t r;
		r.status        = st;
		r.read_byte     = b;
		r.read_has_byte = hb;
		r.read_last     = lst;
		r.occupancy     = OCC_W'(stored_msgs());
		expected_results.insert(expected_results.size(), r);
	endtask

	// Advance the ring mirror by one accepted item and queue its results
	task automatic ring_predict(logic act, logic [7:0] d, logic hb, logic lst, logic ovw);
		int nslots;
		int limit;
		int head;
		int tail;
		int len;
		status_t st;
		nslots = slots_active();
		if (!act) begin
			limit = cfg_max_payload;
			if (limit > MAX_PAYLOAD) limit = MAX_PAYLOAD;
			head = msgs_written & (nslots - 1);
			if (hb) begin
				if (open_fill < limit) begin
					ring_bytes[head * MAX_PAYLOAD + open_fill] = d;
					open_fill++;
				end else begin
					open_too_long = 1'b1;
				end
			end
			if (!lst) begin
				add_expect(ST_BYTE_TAKEN, 8'h00, 1'b0, 1'b1);
			end else begin
				if (open_too_long) begin
					st = ST_OVERSIZE;
				end else if (stored_msgs() >= nslots - 1) begin
					if (ovw) begin
						msgs_read++;
						st = ST_COMMIT_DROP;
					end else begin
						st = ST_FULL_REJECT;
					end
				end else begin
					st = ST_COMMITTED;
				end
				if (st == ST_COMMITTED || st == ST_COMMIT_DROP) begin
					ring_lengths[head] = open_fill;
					msgs_written++;
				end
				open_fill = '0;
				open_too_long = 1'b0;
				add_expect(st, 8'h00, 1'b0, 1'b1);
			end
		end else if (stored_msgs() == 0) begin
			add_expect(ST_POP_EMPTY, 8'h00, 1'b0, 1'b1);
		end else begin
			tail = msgs_read & (nslots - 1);
			len = ring_lengths[tail];
			msgs_read++;
			if (len == 0) begin
				add_expect(ST_POP_DATA, 8'h00, 1'b0, 1'b1);
			end else begin
				for (int i = 0; i < len; i++)
					add_expect(ST_POP_DATA, ring_bytes[tail * MAX_PAYLOAD + i], 1'b1,
						i == len - 1);
			end
		end
	endtask

	// Offer one item from a falling edge; return at the falling edge after it is taken
	task automatic send_item(logic act, logic [7:0] d, logic hb, logic lst, logic ovw);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		action           = act;
		data_byte        = d;
		has_byte         = hb;
		last_byte        = lst;
		overwrite_oldest = ovw;
		push             = 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		ring_predict(act, d, hb, lst, ovw);
		items_accepted++;
		@(negedge clk);
	endtask

	// Push a whole message of random bytes, with an occasional empty inner item
	task automatic push_message(int len, logic ovw);
		if (len == 0) begin
			send_item(1'b0, 8'($urandom), 1'b0, 1'b1, ovw);
		end else begin
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < 8)
					send_item(1'b0, 8'($urandom), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
				send_item(1'b0, 8'($urandom), 1'b1, i == len - 1,
					(i == len - 1) ? ovw : 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Pop with random values on the ignored fields
	task automatic pop_message();
		send_item(1'b1, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_MAX_PAYLOAD)
			cfg_max_payload = val;
		else
			cfg_ring_log2 = val[LOG2_W-1:0];
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait for every queued result, then let the pipeline go quiet
	task automatic wait_drained();
		push = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	// Close any open message, empty the ring and wait for all results
	task automatic settle_ring();
		if (open_fill != 0 || open_too_long)
			send_item(1'b0, 8'($urandom), 1'b0, 1'b1, 1'b0);
		while (stored_msgs() != 0) pop_message();
		wait_drained();
	endtask

	task automatic reconfigure(logic [LEN_W-1:0] max_bytes, logic [LEN_W-1:0] log2_val);
		settle_ring();
		cfg_write(REG_MAX_PAYLOAD, max_bytes);
		cfg_write(REG_RING_LOG2, log2_val);
	endtask

	task automatic random_traffic(int n_items, int idle_pct, int stall_pct);
		int start;
		int pick;
		int limit;
		int len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = items_accepted;
		while (items_accepted - start < n_items) begin
			pick = $urandom_range(0, 99);
			limit = (cfg_max_payload > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_max_payload;
			if (pick < 55) begin
				// mostly short messages, now and then one at or just past the limit
				if ($urandom_range(0, 19) == 0)
					len = limit + $urandom_range(0, 1);
				else
					len = $urandom_range(0, (limit < 6) ? limit + 1 : 6);
				push_message(len, 1'($urandom_range(0, 1)));
			end else if (pick < 90) begin
				pop_message();
			end else begin
				send_item(1'b0, 8'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
		settle_ring();
	endtask

	// Receiver: random stalls plus an optional long hold-off
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop = 1'b0;
				hold_left--;
			end else begin
				pop = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
			error_count++;
		end
	endtask

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && push && full) full_stall_cycles++;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d byte %0d",
					$time, status, read_byte);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				check_field("status", want.status, status);
				check_field("read_byte", want.read_byte, read_byte);
				check_field("read_has_byte", want.read_has_byte, read_has_byte);
				check_field("read_last", want.read_last, read_last);
				check_field("occupancy", want.occupancy, occupancy);
			end
		end
	end

	// Empty ring pop, zero-length message, byte extremes, empty inner item
	task automatic test_basic_cases();
		pop_message();
		push_message(0, 1'b0);
		pop_message();
		send_item(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
		send_item(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
		send_item(1'b0, 8'hFF, 1'b1, 1'b1, 1'b0);
		pop_message();
		wait_drained();
	endtask

	// Pop the stored message while another is half pushed
	task automatic test_pop_during_push();
		send_item(1'b0, 8'hA5, 1'b1, 1'b1, 1'b0);
		send_item(1'b0, 8'h3C, 1'b1, 1'b0, 1'b0);
		pop_message();
		send_item(1'b0, 8'hC3, 1'b1, 1'b1, 1'b0);
		pop_message();
		pop_message();
		wait_drained();
	endtask

	// Smallest ring (size register below range): reject, drop, oversize while full
	task automatic test_ring_full();
		reconfigure(7'd2, 7'd0);
		send_item(1'b0, 8'h11, 1'b1, 1'b1, 1'b0);
		send_item(1'b0, 8'h22, 1'b1, 1'b1, 1'b0);
		send_item(1'b0, 8'h33, 1'b1, 1'b0, 1'b0);
		send_item(1'b0, 8'h44, 1'b1, 1'b1, 1'b1);
		send_item(1'b0, 8'h55, 1'b1, 1'b0, 1'b0);
		send_item(1'b0, 8'h66, 1'b1, 1'b0, 1'b0);
		send_item(1'b0, 8'h77, 1'b1, 1'b1, 1'b1);
		pop_message();
		pop_message();
		wait_drained();
	endtask

	// Zero limit admits only empty messages
	task automatic test_zero_limit();
		reconfigure(7'd0, 7'd1);
		push_message(0, 1'b0);
		send_item(1'b0, 8'h81, 1'b1, 1'b1, 1'b0);
		pop_message();
		pop_message();
		wait_drained();
	endtask

	// Size register above range clamps to all slots; limit above 64 clamps too
	task automatic test_large_ring();
		reconfigure(7'd127, 7'd7);
		for (int i = 0; i < SLOTS - 1; i++) push_message(1, 1'b0);
		push_message(1, 1'b0);
		push_message(1, 1'b1);
		push_message(MAX_PAYLOAD + 1, 1'b1);
		settle_ring();
	endtask

	// Sender and receiver idle patterns at the reset-like setting
	task automatic test_idle_patterns();
		reconfigure(7'd64, 7'd4);
		random_traffic(6, 0, 0);
		random_traffic(6, 54, 0);
		random_traffic(6, 0, 54);
		random_traffic(6, 25, 25);
	endtask

	task automatic test_small_settings();
		reconfigure(7'd5, 7'd2);
		random_traffic(5, 25, 25);
		reconfigure(7'h7B, 7'h7B);
		random_traffic(4, 0, 0);
	endtask

	// Hold the receiver off long enough for the block to fill and stop taking items
	task automatic test_backpressure();
		reconfigure(7'd64, 7'd4);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 150;
		for (int i = 0; i < 6; i++) begin
			push_message($urandom_range(1, 2), 1'b0);
			if (i % 3 == 2) pop_message();
		end
		settle_ring();
	endtask

	initial begin
		arst_n           = 1'b0;
		push             = 1'b0;
		action           = 1'b0;
		data_byte        = 8'h00;
		has_byte         = 1'b0;
		last_byte        = 1'b0;
		overwrite_oldest = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = REG_MAX_PAYLOAD;
		cfg_data         = '0;
		msgs_written     = '0;
		msgs_read        = '0;
		open_fill        = '0;
		open_too_long    = 1'b0;
		cfg_max_payload  = RST_MAX_PAYLOAD;
		cfg_ring_log2    = RST_RING_LOG2;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		hold_left        = 0;
		items_accepted   = 0;
		results_checked  = 0;
		cfg_writes       = 0;
		full_stall_cycles = 0;
		error_count      = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_cases();
		test_pop_during_push();
		test_ring_full();
		test_zero_limit();
		test_large_ring();
		test_idle_patterns();
		test_small_settings();
		test_backpressure();
		wait_drained();

		$display("summary: %0d items sent, %0d results checked, %0d register writes",
			items_accepted, results_checked, cfg_writes);
		$display("summary: rings of 2 to 16 slots, limits 0 to 64 bytes, %0d cycles held on full",
			full_stall_cycles);
		if (error_count == 0)
			$display("packet_ring_fifo_overwrite_tb: done, clean");
		else
			$display("packet_ring_fifo_overwrite_tb: done, errors");
		$finish;
	end

endmodule
